>>> hdl/mcd_pkg.sv
// ----------------------------------------------------------------------------
// mcd_pkg: shared types and constants of the morse code decoder
// Field widths, symbol and opcode codes, queue command format and the
// table index to ascii mapping.
// ----------------------------------------------------------------------------
package mcd_pkg;

  // default parameter values
  localparam int unsigned LETTER_COUNT_DEF = 26;
  localparam int unsigned DIGIT_COUNT_DEF  = 10;
  localparam int unsigned MAX_CODE_LEN_DEF = 7;

  // fixed field widths
  localparam int unsigned SYMBOL_W  = 2;
  localparam int unsigned ENTRY_W   = 6;
  localparam int unsigned LEN_W     = 3;
  localparam int unsigned PAT_W     = 7;
  localparam int unsigned CHAR_W    = 7;

  // depth of the command queue between front and back (power of two)
  localparam int unsigned QUEUE_DEPTH = 4;

  // opcode codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SYMBOL = 1'b1;

  // symbol codes
  localparam logic [SYMBOL_W-1:0] SYM_DOT   = 2'd0;
  localparam logic [SYMBOL_W-1:0] SYM_DASH  = 2'd1;
  localparam logic [SYMBOL_W-1:0] SYM_SPACE = 2'd2;

  // ascii characters
  localparam logic [CHAR_W-1:0] CHAR_A       = 7'd65;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_BLANK   = 7'd32;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'd10;

  // spaces that close a letter and that emit a blank
  localparam logic [LEN_W-1:0] LETTER_GAP = 3'd3;
  localparam logic [LEN_W-1:0] WORD_GAP   = 3'd7;

  typedef enum logic {
    CMD_LOAD,
    CMD_DECODE
  } cmd_kind_e;

  typedef enum logic [1:0] {
    TRAIL_NONE,
    TRAIL_BLANK,
    TRAIL_NEWLINE
  } trail_e;

  // one command from front to back
  typedef struct packed {
    cmd_kind_e               kind;
    logic [ENTRY_W-1:0]      idx;
    logic [LEN_W-1:0]        len;
    logic [PAT_W-1:0]        pat;
    logic                    search;
    trail_e                  trail;
  } cmd_t;

  // table entry index to ascii: letters from 'A', then digits from '0'
  function automatic logic [CHAR_W-1:0] char_of(logic [ENTRY_W-1:0] idx,
                                                int unsigned letters);
    logic [CHAR_W-1:0] c;
    if (int'(idx) < int'(letters)) begin
      c = CHAR_W'(int'(CHAR_A) + int'(idx));
    end else begin
      c = CHAR_W'(int'(CHAR_ZERO) + int'(idx) - int'(letters));
    end
    return c;
  endfunction

endpackage

>>> hdl/mcd_if.sv
// ----------------------------------------------------------------------------
// mcd_if: channel interfaces of the morse code decoder
// Valid/ready channels for symbol and load items in, characters out.
// ----------------------------------------------------------------------------
interface mcd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [mcd_pkg::SYMBOL_W-1:0]  symbol;
  logic                          line_end;
  logic [mcd_pkg::ENTRY_W-1:0]   entry_index;
  logic [mcd_pkg::LEN_W-1:0]     code_length;
  logic [mcd_pkg::PAT_W-1:0]     code_pattern;

  modport source (output valid, opcode, symbol, line_end, entry_index, code_length,
                  code_pattern, input ready);
  modport sink (input valid, opcode, symbol, line_end, entry_index, code_length,
                code_pattern, output ready);
endinterface

interface mcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mcd_pkg::CHAR_W-1:0]  out_char;
  logic                        last;

  modport source (output valid, out_char, last, input ready);
  modport sink (input valid, out_char, last, output ready);
endinterface

>>> hdl/mcd_queue.sv
// ----------------------------------------------------------------------------
// mcd_queue: command queue between front and back
// Small register fifo; lets the front keep taking items while the back
// searches the table or waits on the output.
// ----------------------------------------------------------------------------
module mcd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcd_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mcd_pkg::cmd_t pop_data_o
);
  import mcd_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == (PtrW+1)'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = (PtrW+1)'(count_q + 1'b1);
    end else if (!do_push && do_pop) begin
      count_d = (PtrW+1)'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/mcd_front.sv
// ----------------------------------------------------------------------------
// mcd_front: symbol front end
// Accepts items, gathers dots and dashes into a code, counts spaces and
// turns table loads and closed letters into commands for the back end.
// ----------------------------------------------------------------------------
module mcd_front #(
  parameter int unsigned TABLE_DEPTH  = mcd_pkg::LETTER_COUNT_DEF + mcd_pkg::DIGIT_COUNT_DEF,
  parameter int unsigned MAX_CODE_LEN = mcd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mcd_in_if.sink        in_i,
  output logic          push_o,
  output mcd_pkg::cmd_t cmd_o,
  input  logic          full_i
);
  import mcd_pkg::*;

  // longest code that fits the pattern register
  localparam int unsigned CodeCap = (MAX_CODE_LEN < PAT_W) ? MAX_CODE_LEN : PAT_W;

  logic [LEN_W-1:0] len_q, len_d;
  logic [PAT_W-1:0] pat_q, pat_d;
  logic             ovf_q, ovf_d;
  logic [LEN_W-1:0] space_q, space_d;
  logic [LEN_W-1:0] space_inc;
  logic             accept;
  logic             close_req;
  trail_e           trail;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign space_inc  = LEN_W'(space_q + 1'b1);

  // classify the item and build the command
  always_comb begin
    len_d     = len_q;
    pat_d     = pat_q;
    ovf_d     = ovf_q;
    space_d   = space_q;
    close_req = 1'b0;
    trail     = TRAIL_NONE;
    push_o    = 1'b0;
    cmd_o     = '{kind: CMD_DECODE, idx: in_i.entry_index, len: '0, pat: '0,
                  search: 1'b0, trail: TRAIL_NONE};

    if (in_i.opcode == OP_LOAD) begin
      // table load, pattern bits above the length cleared
      cmd_o.kind = CMD_LOAD;
      cmd_o.len  = in_i.code_length;
      cmd_o.pat  = in_i.code_pattern & PAT_W'((8'd1 << in_i.code_length) - 8'd1);
      push_o     = accept && (in_i.entry_index < ENTRY_W'(TABLE_DEPTH));
    end else begin
      // dot or dash extends the code
      if (in_i.symbol == SYM_DOT || in_i.symbol == SYM_DASH) begin
        space_d = '0;
        if (len_q < LEN_W'(CodeCap)) begin
          if (in_i.symbol == SYM_DASH) begin
            pat_d = pat_q | (PAT_W'(1) << len_q);
          end
          len_d = LEN_W'(len_q + 1'b1);
        end else begin
          ovf_d = 1'b1;
        end
      end else if (in_i.symbol == SYM_SPACE && !in_i.line_end) begin
        // letter gap and word gap
        space_d = space_inc;
        if (space_inc == LETTER_GAP) begin
          close_req = 1'b1;
        end
        if (space_inc == WORD_GAP) begin
          close_req = 1'b1;
          trail     = TRAIL_BLANK;
          space_d   = '0;
        end
      end

      if (in_i.line_end) begin
        close_req = 1'b1;
        trail     = TRAIL_NEWLINE;
        space_d   = '0;
      end

      // close the letter
      if (close_req) begin
        cmd_o.len    = len_d;
        cmd_o.pat    = pat_d;
        cmd_o.search = (len_d != '0) && !ovf_d;
        cmd_o.trail  = trail;
        push_o       = accept && (cmd_o.search || trail != TRAIL_NONE);
        len_d        = '0;
        pat_d        = '0;
        ovf_d        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      pat_q   <= '0;
      ovf_q   <= 1'b0;
      space_q <= '0;
    end else if (accept && in_i.opcode == OP_SYMBOL) begin
      len_q   <= len_d;
      pat_q   <= pat_d;
      ovf_q   <= ovf_d;
      space_q <= space_d;
    end
  end

endmodule

>>> hdl/mcd_back.sv
// ----------------------------------------------------------------------------
// mcd_back: table back end
// Holds the code table, writes loads, searches it one entry a cycle for a
// closed letter and drives the characters through an output register.
// ----------------------------------------------------------------------------
module mcd_back #(
  parameter int unsigned LETTER_COUNT = mcd_pkg::LETTER_COUNT_DEF,
  parameter int unsigned DIGIT_COUNT  = mcd_pkg::DIGIT_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  mcd_pkg::cmd_t cmd_i,
  output logic          pop_o,
  mcd_out_if.source     out_o
);
  import mcd_pkg::*;

  localparam int unsigned Depth = LETTER_COUNT + DIGIT_COUNT;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pat;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT_CHAR,
    ST_EMIT_TRAIL
  } state_e;

  entry_t             table_mem [Depth];
  entry_t             rd_q;
  logic               rd_en;
  logic               wr_en;

  state_e             state_q, state_d;
  cmd_t               cur_q, cur_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic               issue_q, issue_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [AddrW-1:0]   cmp_idx_q, cmp_idx_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               out_vld_q, out_vld_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;
  logic               slot_free;
  logic               hit;

  assign slot_free      = !out_vld_q || out_o.ready;
  assign out_o.valid    = out_vld_q;
  assign out_o.out_char = out_char_q;
  assign out_o.last     = out_last_q;
  assign hit            = cmp_vld_q && (rd_q.len == cur_q.len) && (rd_q.pat == cur_q.pat);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    addr_d     = addr_q;
    issue_d    = issue_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    char_d     = char_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_char_d = out_char_q;
    out_last_d = out_last_q;
    pop_o      = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          cur_d = cmd_i;
          if (cmd_i.kind == CMD_LOAD) begin
            wr_en = 1'b1;
          end else if (cmd_i.search) begin
            state_d = ST_SEARCH;
            addr_d  = '0;
            issue_d = 1'b1;
          end else begin
            state_d = ST_EMIT_TRAIL;
          end
        end
      end
      ST_SEARCH: begin
        // read one entry a cycle, compare the one read the cycle before
        if (issue_q) begin
          rd_en     = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = addr_q;
          addr_d    = AddrW'(addr_q + 1'b1);
          if (addr_q == AddrW'(Depth - 1)) begin
            issue_d = 1'b0;
          end
        end
        if (hit) begin
          char_d    = char_of(ENTRY_W'(cmp_idx_q), LETTER_COUNT);
          state_d   = ST_EMIT_CHAR;
          issue_d   = 1'b0;
          cmp_vld_d = 1'b0;
        end else if (cmp_vld_q && cmp_idx_q == AddrW'(Depth - 1)) begin
          state_d = (cur_q.trail != TRAIL_NONE) ? ST_EMIT_TRAIL : ST_IDLE;
        end
      end
      ST_EMIT_CHAR: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_char_d = char_q;
          out_last_d = (cur_q.trail == TRAIL_NONE);
          state_d    = (cur_q.trail != TRAIL_NONE) ? ST_EMIT_TRAIL : ST_IDLE;
        end
      end
      ST_EMIT_TRAIL: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_char_d = (cur_q.trail == TRAIL_BLANK) ? CHAR_BLANK : CHAR_NEWLINE;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      issue_q    <= 1'b0;
      cmp_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      cur_q      <= '0;
      addr_q     <= '0;
      cmp_idx_q  <= '0;
      char_q     <= '0;
      out_char_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      issue_q    <= issue_d;
      cmp_vld_q  <= cmp_vld_d;
      out_vld_q  <= out_vld_d;
      cur_q      <= cur_d;
      addr_q     <= addr_d;
      cmp_idx_q  <= cmp_idx_d;
      char_q     <= char_d;
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  // code table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[cmd_i.idx[AddrW-1:0]] <= '{len: cmd_i.len, pat: cmd_i.pat};
    end
    if (rd_en) begin
      rd_q <= table_mem[addr_q];
    end
  end

endmodule

>>> hdl/morse_code_decoder.sv
// ----------------------------------------------------------------------------
// morse_code_decoder: morse symbol stream to ascii characters
// Front end gathers symbols into codes, a command queue decouples it from
// the back end that searches the loadable code table.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item per valid/ready handshake: opcode 0 loads a table
//   entry (entry_index, code_length, code_pattern), opcode 1 delivers a dot,
//   dash or space, with line_end marking the last symbol of a line.
//   out_o carries characters (A-Z, 0-9, blank, newline); last flags the final
//   character caused by one item, at most two per item.
// Timing:
//   the front takes one item per cycle while the four-entry command queue
//   has room. A load is written into the table as the back pops it. A
//   closed letter is searched one table entry per cycle over the single
//   memory read port; its character then goes to the output register,
//   followed by a trailing blank or newline if the letter has one.
// Reset:
//   clears the code in progress, space count, queue and output; the table
//   is not cleared and must be loaded before use.
// Stalls:
//   when out_o is not ready the back end holds, the queue fills and then
//   in_i.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module morse_code_decoder #(
  parameter int unsigned LETTER_COUNT = mcd_pkg::LETTER_COUNT_DEF,
  parameter int unsigned DIGIT_COUNT  = mcd_pkg::DIGIT_COUNT_DEF,
  parameter int unsigned MAX_CODE_LEN = mcd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcd_in_if.sink    in_i,
  mcd_out_if.source out_o
);
  import mcd_pkg::*;

  localparam int unsigned TableDepth = LETTER_COUNT + DIGIT_COUNT;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_wr_cmd;
  cmd_t q_rd_cmd;

  // symbol front end
  mcd_front #(
    .TABLE_DEPTH  (TableDepth),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (q_push),
    .cmd_o  (q_wr_cmd),
    .full_i (q_full)
  );

  // command queue
  mcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wr_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rd_cmd)
  );

  // table search back end
  mcd_back #(
    .LETTER_COUNT (LETTER_COUNT),
    .DIGIT_COUNT  (DIGIT_COUNT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (q_rd_cmd),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  // front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("command pushed into full queue");

  // back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("command popped from empty queue");

  // a pushed command into an empty queue is visible to the back next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   q_push && !q_valid |=> q_valid)
    else $error("queue lost a command");

endmodule
